[rtl/core/twmm_pkg.sv]
// Shared types and constants of the text window memory mapper.
// Used by the divider, the top level, the checkers and the testbench.
package twmm_pkg;

    localparam int TWMM_CELLS     = 2048;
    localparam int TWMM_REG_IDX_W = 3;
    localparam int TWMM_DIV_W     = 17;
    localparam int TWMM_IDX_W     = 17;

    localparam logic [7:0] TWMM_TEXT_FILL  = 8'h20;
    localparam logic [7:0] TWMM_COLOR_FILL = 8'h01;

    localparam logic [TWMM_REG_IDX_W-1:0] REG_WIN_X         = 3'd0;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_WIN_Y         = 3'd1;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_WIN_WIDTH     = 3'd2;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_WIN_HEIGHT    = 3'd3;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_TEXT_PAGE     = 3'd4;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_COLOR_PAGE    = 3'd5;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd6;
    localparam logic [TWMM_REG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd7;

    typedef struct packed {
        logic        op;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } twmm_req_t;

    typedef struct packed {
        logic       hit;
        logic       is_color;
        logic       cell_update;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [7:0] value;
        logic       inverse;
    } twmm_rsp_t;

endpackage

[rtl/core/twmm_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// Payload types come from twmm_pkg.
interface twmm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/twmm_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Standalone; no package dependency.
module twmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/core/twmm_div.sv]
// Restoring divider, one quotient bit per cycle, 8-bit divisor.
// Depends on twmm_pkg for the dividend width.
module twmm_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [twmm_pkg::TWMM_DIV_W-1:0]   dividend,
    input  logic [7:0]                        divisor,
    output logic                              done,
    output logic [twmm_pkg::TWMM_DIV_W-1:0]   quotient,
    output logic [7:0]                        remainder
);
    import twmm_pkg::*;

    localparam int CNT_W = $clog2(TWMM_DIV_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [TWMM_DIV_W-1:0] quo_reg;
    logic [7:0]            rem_reg;
    logic [7:0]            dvs_reg;
    logic [8:0]            trial;
    logic [8:0]            diff;
    logic                  ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[TWMM_DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(TWMM_DIV_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[7:0] : trial[7:0];
            quo_reg <= {quo_reg[TWMM_DIV_W-2:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/text_window_memory_mapper.sv]
// Top level of the text window memory mapper: decode, sequencer, plane RAMs.
// Depends on twmm_pkg, twmm_stream_if, twmm_ram and twmm_div.
// One bus access is handled at a time. A miss, or a hit while a screen size is
// zero, is held in the result register and moves into the output register in the
// output state once that register is free; a mapped access runs three passes of the
// shared restoring divider (17 quotient bits each: offset by window width, column
// by screen width, row by screen height), then a multiply-add for the cell index,
// the RAM state and, for a read, a read state. A new access is taken while the
// previous result still waits in the output register. After reset both planes
// are filled, CELLS cells each (2048 by default), one cell per cycle; no access is
// taken until then, while register writes are taken at any time.
module text_window_memory_mapper #(
    parameter int CELLS = twmm_pkg::TWMM_CELLS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    twmm_stream_if.sink                          req,
    twmm_stream_if.source                        rsp,
    input  logic                                 cfg_we,
    input  logic [twmm_pkg::TWMM_REG_IDX_W-1:0]  cfg_idx,
    input  logic [7:0]                           cfg_wdata
);
    import twmm_pkg::*;

    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [AW-1:0]         LAST_CELL = AW'(CELLS - 1);
    localparam logic [TWMM_IDX_W-1:0] CELL_LIM  = TWMM_IDX_W'(CELLS);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIVW,
        S_DIVX,
        S_DIVY,
        S_MUL,
        S_MEM,
        S_RD,
        S_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_cnt_reg, clr_cnt_next;
    logic                  op_reg, op_next;
    logic [7:0]            wdata_reg, wdata_next;
    logic                  color_reg, color_next;
    logic [TWMM_DIV_W-1:0] qy_reg, qy_next;
    logic [7:0]            cx_reg, cx_next;
    logic [7:0]            cy_reg, cy_next;
    logic [TWMM_IDX_W-1:0] idx_reg, idx_next;
    twmm_rsp_t             res_reg, res_next;
    twmm_rsp_t             out_reg, out_next;
    logic                  ovalid_reg, ovalid_next;

    logic [7:0] win_x_reg, win_y_reg, win_width_reg, win_height_reg;
    logic [7:0] text_page_reg, color_page_reg, screen_width_reg, screen_height_reg;

    logic [15:0]           area;
    logic [15:0]           area_rnd;
    logic [8:0]            banks;
    logic [8:0]            pg;
    logic                  color_hit;
    logic                  text_hit;
    logic [7:0]            base;
    logic [15:0]           off;
    logic [8:0]            cx_pre;
    logic                  in_range;

    logic                  div_start;
    logic [TWMM_DIV_W-1:0] div_dividend;
    logic [7:0]            div_divisor;
    logic                  div_done;
    logic [TWMM_DIV_W-1:0] div_quo;
    logic [7:0]            div_rem;

    logic                  t_we;
    logic                  c_we;
    logic [AW-1:0]         mem_addr;
    logic [7:0]            t_wdata;
    logic [7:0]            c_wdata;
    logic [7:0]            t_rdata;
    logic [7:0]            c_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_x_reg         <= 8'd0;
            win_y_reg         <= 8'd0;
            win_width_reg     <= 8'd40;
            win_height_reg    <= 8'd25;
            text_page_reg     <= 8'd4;
            color_page_reg    <= 8'd216;
            screen_width_reg  <= 8'd40;
            screen_height_reg <= 8'd25;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_WIN_X:         win_x_reg         <= cfg_wdata;
                REG_WIN_Y:         win_y_reg         <= cfg_wdata;
                REG_WIN_WIDTH:     win_width_reg     <= cfg_wdata;
                REG_WIN_HEIGHT:    win_height_reg    <= cfg_wdata;
                REG_TEXT_PAGE:     text_page_reg     <= cfg_wdata;
                REG_COLOR_PAGE:    color_page_reg    <= cfg_wdata;
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata;
            endcase
        end
    end

    always_comb
    begin
        area      = win_width_reg * win_height_reg;
        area_rnd  = area + 16'd255;
        banks     = {1'b0, area_rnd[15:8]};
        pg        = {1'b0, req.data.addr[15:8]};
        color_hit = (pg >= {1'b0, color_page_reg}) && (pg < ({1'b0, color_page_reg} + banks));
        text_hit  = (pg >= {1'b0, text_page_reg}) && (pg < ({1'b0, text_page_reg} + banks));
        base      = color_hit ? color_page_reg : text_page_reg;
        off       = req.data.addr - {base, 8'h00};
        cx_pre    = {1'b0, div_rem} + {1'b0, win_x_reg};
        in_range  = (idx_reg < CELL_LIM);
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ovalid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        op_next      = op_reg;
        wdata_next   = wdata_reg;
        color_next   = color_reg;
        qy_next      = qy_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        ovalid_next  = ovalid_reg;

        div_start    = 1'b0;
        div_dividend = {1'b0, off};
        div_divisor  = win_width_reg;

        t_we     = 1'b0;
        c_we     = 1'b0;
        mem_addr = idx_reg[AW-1:0];
        t_wdata  = wdata_reg;
        c_wdata  = wdata_reg;

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                t_we     = 1'b1;
                c_we     = 1'b1;
                mem_addr = clr_cnt_reg;
                t_wdata  = TWMM_TEXT_FILL;
                c_wdata  = TWMM_COLOR_FILL;
                if (clr_cnt_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.data.op;
                    wdata_next = req.data.wdata;
                    color_next = color_hit;
                    res_next   = '0;
                    if (!(color_hit || text_hit))
                    begin
                        state_next = S_OUT;
                    end
                    else if (screen_width_reg == 8'd0 || screen_height_reg == 8'd0)
                    begin
                        res_next.hit      = 1'b1;
                        res_next.is_color = color_hit;
                        res_next.value    = req.data.op ? req.data.wdata : 8'd0;
                        state_next        = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVW;
                    end
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    qy_next      = div_quo + TWMM_DIV_W'(win_y_reg);
                    div_start    = 1'b1;
                    div_dividend = TWMM_DIV_W'(cx_pre);
                    div_divisor  = screen_width_reg;
                    state_next   = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    cx_next      = div_rem;
                    div_start    = 1'b1;
                    div_dividend = qy_reg;
                    div_divisor  = screen_height_reg;
                    state_next   = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_done)
                begin
                    cy_next    = div_rem;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                idx_next   = TWMM_IDX_W'(cx_reg)
                           + TWMM_IDX_W'(screen_width_reg) * TWMM_IDX_W'(cy_reg);
                state_next = S_MEM;
            end
            S_MEM:
            begin
                res_next.hit         = 1'b1;
                res_next.is_color    = color_reg;
                res_next.cell_update = 1'b0;
                res_next.cell_x      = cx_reg;
                res_next.cell_y      = cy_reg;
                res_next.value       = op_reg ? wdata_reg : 8'd0;
                res_next.inverse     = 1'b0;
                state_next           = S_OUT;
                if (in_range)
                begin
                    if (op_reg)
                    begin
                        t_we                 = !color_reg;
                        c_we                 = color_reg;
                        res_next.cell_update = 1'b1;
                        res_next.inverse     = !color_reg && wdata_reg[7];
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                res_next.value = color_reg ? c_rdata : t_rdata;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    out_next    = res_reg;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            ovalid_reg  <= 1'b0;
            out_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            ovalid_reg  <= ovalid_next;
            out_reg     <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        wdata_reg <= wdata_next;
        color_reg <= color_next;
        qy_reg    <= qy_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
    end

    twmm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    twmm_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_text_ram (
        .clk   (clk),
        .we    (t_we),
        .addr  (mem_addr),
        .wdata (t_wdata),
        .rdata (t_rdata)
    );

    twmm_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_color_ram (
        .clk   (clk),
        .we    (c_we),
        .addr  (mem_addr),
        .wdata (c_wdata),
        .rdata (c_rdata)
    );

endmodule

[rtl/core/twmm_checker.sv]
// Port-level checks for the text window memory mapper, bound to the top level.
// Depends on twmm_pkg and text_window_memory_mapper.
module twmm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input twmm_pkg::twmm_rsp_t rsp_data
);
    import twmm_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.hit |-> !rsp_data.is_color && !rsp_data.cell_update &&
            rsp_data.cell_x == 8'd0 && rsp_data.cell_y == 8'd0 &&
            rsp_data.value == 8'd0 && !rsp_data.inverse)
        else $error("miss result carries nonzero fields");

    a_update_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.cell_update |-> rsp_data.hit)
        else $error("cell update without a hit");

    a_inverse_text: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.inverse |-> rsp_data.cell_update && !rsp_data.is_color)
        else $error("inverse outside a stored text write");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second transfer taken while busy");

endmodule

bind text_window_memory_mapper twmm_checker u_twmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

[tb/sv/twmm_access_check.sv]
`timescale 1ns / 100ps
// Access checker for the text window memory mapper: watches both streams and the register port.
// Keeps its own plane stores and register copy and compares every response transfer in order.
// Depends on twmm_pkg.
module twmm_access_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  twmm_pkg::twmm_req_t                 req_data,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  twmm_pkg::twmm_rsp_t                 rsp_data,
    input  logic                                cfg_we,
    input  logic [twmm_pkg::TWMM_REG_IDX_W-1:0] cfg_idx,
    input  logic [7:0]                          cfg_wdata,
    output int                                  errors,
    output int                                  results_due
);
    import twmm_pkg::*;

    logic [7:0] text_cells  [TWMM_CELLS];
    logic [7:0] color_cells [TWMM_CELLS];
    logic [7:0] win_x, win_y, win_width, win_height;
    logic [7:0] text_page, color_page, screen_width, screen_height;
    twmm_rsp_t  pending_results [$];
    twmm_rsp_t  want;
    int         fails;

    function automatic twmm_rsp_t map_access(twmm_req_t acc);
        twmm_rsp_t r;
        int banks, page, base, off, col, row, cell_idx;
        r     = '0;
        base  = 0;
        banks = (int'(win_width) * int'(win_height) + 255) / 256;
        page  = int'(acc.addr[15:8]);
        if (page >= int'(color_page) && page < int'(color_page) + banks) begin
            r.hit      = 1'b1;
            r.is_color = 1'b1;
            base       = int'(color_page);
        end
        else if (page >= int'(text_page) && page < int'(text_page) + banks) begin
            r.hit = 1'b1;
            base  = int'(text_page);
        end
        if (r.hit) begin
            if (acc.op)
                r.value = acc.wdata;
            if (screen_width != 8'd0 && screen_height != 8'd0) begin
                off      = int'(acc.addr) - base * 256;
                col      = (off % int'(win_width) + int'(win_x)) % int'(screen_width);
                row      = (off / int'(win_width) + int'(win_y)) % int'(screen_height);
                r.cell_x = col[7:0];
                r.cell_y = row[7:0];
                cell_idx = col + int'(screen_width) * row;
                if (cell_idx < TWMM_CELLS) begin
                    if (acc.op) begin
                        r.cell_update = 1'b1;
                        if (r.is_color)
                            color_cells[cell_idx] = acc.wdata;
                        else
                        begin
                            text_cells[cell_idx] = acc.wdata;
                            r.inverse            = acc.wdata[7];
                        end
                    end
                    else
                    begin
                        r.value = r.is_color ? color_cells[cell_idx] : text_cells[cell_idx];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic int field_diff(string name, logic [7:0] exp_val, logic [7:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TWMM_CELLS; i++)
            begin
                text_cells[i]  = TWMM_TEXT_FILL;
                color_cells[i] = TWMM_COLOR_FILL;
            end
            win_x         = 8'd0;
            win_y         = 8'd0;
            win_width     = 8'd40;
            win_height    = 8'd25;
            text_page     = 8'd4;
            color_page    = 8'd216;
            screen_width  = 8'd40;
            screen_height = 8'd25;
            pending_results.delete();
            errors      <= 0;
            results_due <= 0;
        end
        else
        begin
            fails = 0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_WIN_X:         win_x         = cfg_wdata;
                    REG_WIN_Y:         win_y         = cfg_wdata;
                    REG_WIN_WIDTH:     win_width     = cfg_wdata;
                    REG_WIN_HEIGHT:    win_height    = cfg_wdata;
                    REG_TEXT_PAGE:     text_page     = cfg_wdata;
                    REG_COLOR_PAGE:    color_page    = cfg_wdata;
                    REG_SCREEN_WIDTH:  screen_width  = cfg_wdata;
                    REG_SCREEN_HEIGHT: screen_height = cfg_wdata;
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                pending_results.push_back(map_access(req_data));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("response transfer with no access outstanding");
                    fails++;
                end
                else
                begin
                    want  = pending_results.pop_front();
                    fails += field_diff("hit", 8'(want.hit), 8'(rsp_data.hit));
                    fails += field_diff("is_color", 8'(want.is_color), 8'(rsp_data.is_color));
                    fails += field_diff("cell_update", 8'(want.cell_update),
                                        8'(rsp_data.cell_update));
                    fails += field_diff("cell_x", want.cell_x, rsp_data.cell_x);
                    fails += field_diff("cell_y", want.cell_y, rsp_data.cell_y);
                    fails += field_diff("value", want.value, rsp_data.value);
                    fails += field_diff("inverse", 8'(want.inverse), 8'(rsp_data.inverse));
                end
            end
            errors      <= errors + fails;
            results_due <= pending_results.size();
        end
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// Top of the text window memory mapper testbench: clock, reset, register writes and bus accesses.
// Depends on twmm_pkg, twmm_stream_if, the mapper RTL and twmm_access_check.
module tb;
    import twmm_pkg::*;

    localparam logic OP_READ       = 1'b0;
    localparam logic OP_WRITE      = 1'b1;
    localparam int   RUN_LIMIT     = 800000;
    localparam int   RANDOM_PHASES = 9;
    localparam int   PHASE_ITEMS   = 125;
    localparam int   TAIL_CYCLES   = 100;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [TWMM_REG_IDX_W-1:0] cfg_idx;
    logic [7:0]                cfg_wdata;
    logic [7:0]                cur_cfg [8];
    int                        error_count;
    int                        results_due;
    int                        cycle_count   = 0;
    int                        src_idle_pct  = 25;
    int                        sink_idle_pct = 78;

    twmm_stream_if #(.T(twmm_req_t)) req ();
    twmm_stream_if #(.T(twmm_rsp_t)) rsp ();

    text_window_memory_mapper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    twmm_access_check access_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_data    (req.data),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .rsp_data    (rsp.data),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .errors      (error_count),
        .results_due (results_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        rsp.ready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [TWMM_REG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we       <= 1'b1;
        cfg_idx      <= idx;
        cfg_wdata    <= val;
        cur_cfg[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_access(input logic op, input logic [15:0] addr, input logic [7:0] wdata);
        twmm_req_t acc;
        acc.op    = op;
        acc.addr  = addr;
        acc.wdata = wdata;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= acc;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // drop valid and hold until every response transfer has come back
    task automatic drain();
        req.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    task automatic pick_config();
        logic [7:0] wx, wy, ww, wh, tp, cp, sw, sh;
        int         kind;
        kind = $urandom_range(0, 9);
        wx   = 8'($urandom_range(0, 255));
        wy   = 8'($urandom_range(0, 255));
        ww   = 8'($urandom_range(1, 40));
        wh   = 8'($urandom_range(1, 25));
        sw   = 8'($urandom_range(1, 64));
        sh   = 8'($urandom_range(1, 32));
        tp   = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 2) == 0)
            cp = tp + 8'($urandom_range(0, 3));
        else
            cp = 8'($urandom_range(0, 255));
        case (kind)
            6:
            begin
                ww = 8'd255;
                wh = 8'($urandom_range(1, 255));
                sw = $urandom_range(0, 1) ? 8'd255 : 8'd1;
                sh = $urandom_range(0, 1) ? 8'd255 : 8'd1;
            end
            7:
            begin
                if ($urandom_range(0, 1))
                    ww = 8'd0;
                else
                    wh = 8'd0;
            end
            8:
            begin
                if ($urandom_range(0, 1))
                    sw = 8'd0;
                else
                    sh = 8'd0;
            end
            9:
            begin
                ww = 8'($urandom_range(0, 255));
                wh = 8'($urandom_range(0, 255));
                sw = 8'($urandom_range(0, 255));
                sh = 8'($urandom_range(0, 255));
            end
            default: ;
        endcase
        write_reg(REG_WIN_X, wx);
        write_reg(REG_WIN_Y, wy);
        write_reg(REG_WIN_WIDTH, ww);
        write_reg(REG_WIN_HEIGHT, wh);
        write_reg(REG_TEXT_PAGE, tp);
        write_reg(REG_COLOR_PAGE, cp);
        write_reg(REG_SCREEN_WIDTH, sw);
        write_reg(REG_SCREEN_HEIGHT, sh);
    endtask

    task automatic send_random();
        int          banks, base, pick;
        logic [15:0] addr;
        banks = (int'(cur_cfg[REG_WIN_WIDTH]) * int'(cur_cfg[REG_WIN_HEIGHT]) + 255) / 256;
        pick  = $urandom_range(0, 99);
        if (banks == 0 || pick >= 90)
            addr = 16'($urandom_range(0, 16'hFFFF));
        else
        begin
            if (pick < 45)
                base = int'(cur_cfg[REG_TEXT_PAGE]);
            else
                base = int'(cur_cfg[REG_COLOR_PAGE]);
            // keep half the in-plane accesses near the plane start so reads meet earlier writes
            if ($urandom_range(0, 1))
                addr = 16'(base * 256 + $urandom_range(0, 63));
            else
                addr = 16'(base * 256 + $urandom_range(0, banks * 256 - 1));
        end
        if ($urandom_range(0, 1))
            send_access(OP_WRITE, addr, 8'($urandom_range(0, 255)));
        else
            send_access(OP_READ, addr, 8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        req.valid = 1'b0;
        req.data  = '0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        cur_cfg   = '{8'd0, 8'd0, 8'd40, 8'd25, 8'd4, 8'd216, 8'd40, 8'd25};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: fills, read-back, plane edges, misses
        send_access(OP_READ, 16'h0400, 8'h00);
        send_access(OP_READ, 16'hD800, 8'h00);
        send_access(OP_WRITE, 16'h0400, 8'hFF);
        send_access(OP_READ, 16'h0400, 8'h00);
        send_access(OP_WRITE, 16'hD800, 8'h00);
        send_access(OP_READ, 16'hD800, 8'hFF);
        send_access(OP_READ, 16'h07FF, 8'h00);
        send_access(OP_READ, 16'h0800, 8'h00);
        send_access(OP_WRITE, 16'h03FF, 8'h7F);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_WRITE, 16'hFFFF, 8'hAA);

        // overlapping planes running past the top page, cell index out of range
        drain();
        write_reg(REG_TEXT_PAGE, 8'd8);
        write_reg(REG_COLOR_PAGE, 8'd8);
        write_reg(REG_WIN_WIDTH, 8'd255);
        write_reg(REG_WIN_HEIGHT, 8'd255);
        write_reg(REG_SCREEN_WIDTH, 8'd255);
        write_reg(REG_SCREEN_HEIGHT, 8'd255);
        send_access(OP_READ, 16'hFFFF, 8'h00);
        send_access(OP_WRITE, 16'h0800, 8'h80);
        send_access(OP_READ, 16'h0800, 8'h00);
        send_access(OP_READ, 16'h0700, 8'h00);

        // zero window width
        drain();
        write_reg(REG_WIN_WIDTH, 8'd0);
        send_access(OP_READ, 16'h0800, 8'h00);
        send_access(OP_WRITE, 16'h2000, 8'h33);

        // zero screen width, then zero screen height
        drain();
        write_reg(REG_WIN_WIDTH, 8'd16);
        write_reg(REG_WIN_HEIGHT, 8'd16);
        write_reg(REG_SCREEN_WIDTH, 8'd0);
        send_access(OP_READ, 16'h0800, 8'h00);
        send_access(OP_WRITE, 16'h0801, 8'h55);
        drain();
        write_reg(REG_SCREEN_WIDTH, 8'd40);
        write_reg(REG_SCREEN_HEIGHT, 8'd0);
        send_access(OP_READ, 16'h0800, 8'h00);

        // origin at its maximum wraps both coordinates
        drain();
        write_reg(REG_SCREEN_HEIGHT, 8'd25);
        write_reg(REG_WIN_X, 8'd255);
        write_reg(REG_WIN_Y, 8'd255);
        write_reg(REG_TEXT_PAGE, 8'd0);
        write_reg(REG_COLOR_PAGE, 8'd255);
        send_access(OP_WRITE, 16'h0000, 8'h81);
        send_access(OP_READ, 16'h0000, 8'h00);
        send_access(OP_READ, 16'hFFFF, 8'h00);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            if (phase < 3)
            begin
                src_idle_pct  = 25;
                sink_idle_pct = 78;
            end
            else if (phase < 6)
            begin
                src_idle_pct  = 78;
                sink_idle_pct = 25;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            pick_config();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
